@@ sv/jfs_pkg.sv @@
package jfs_pkg;

	localparam int unsigned PHASE_W = 4;
	localparam int unsigned HDR_IDX_W = 3;

	localparam logic [PHASE_W-1:0] PH_EXPECT_FF = 4'd0;
	localparam logic [PHASE_W-1:0] PH_EXPECT_D8 = 4'd1;
	localparam logic [PHASE_W-1:0] PH_HUNT      = 4'd2;
	localparam logic [PHASE_W-1:0] PH_FF_RUN    = 4'd3;
	localparam logic [PHASE_W-1:0] PH_LEN_HI    = 4'd4;
	localparam logic [PHASE_W-1:0] PH_LEN_LO    = 4'd5;
	localparam logic [PHASE_W-1:0] PH_SKIP      = 4'd6;
	localparam logic [PHASE_W-1:0] PH_SOF_BODY  = 4'd7;
	localparam logic [PHASE_W-1:0] PH_DONE      = 4'd8;

	localparam logic [7:0] MK_FILL = 8'hFF;
	localparam logic [7:0] MK_SOI  = 8'hD8;
	localparam logic [7:0] MK_EOI  = 8'hD9;
	localparam logic [7:0] MK_RST0 = 8'hD0;
	localparam logic [7:0] MK_RST7 = 8'hD7;
	localparam logic [7:0] MK_SOF0 = 8'hC0;
	localparam logic [7:0] MK_SOF_LAST = 8'hCF;
	localparam logic [7:0] MK_DHT  = 8'hC4;
	localparam logic [7:0] MK_JPG  = 8'hC8;
	localparam logic [7:0] MK_DAC  = 8'hCC;

	localparam logic [15:0] LEN_MIN     = 16'd2;
	localparam logic [15:0] SOF_LEN_MIN = 16'd7;

	localparam logic [HDR_IDX_W-1:0] HDR_H_HI = 3'd1;
	localparam logic [HDR_IDX_W-1:0] HDR_H_LO = 3'd2;
	localparam logic [HDR_IDX_W-1:0] HDR_W_HI = 3'd3;
	localparam logic [HDR_IDX_W-1:0] HDR_W_LO = 3'd4;
	localparam logic [HDR_IDX_W-1:0] HDR_END  = 3'd5;

	typedef struct packed {
		logic [PHASE_W-1:0]   phase;
		logic [15:0]          segment_left;
		logic [7:0]           marker_code;
		logic [7:0]           length_high;
		logic [HDR_IDX_W-1:0] header_index;
		logic [15:0]          held_width;
		logic [15:0]          held_height;
		logic                 result_given;
	} jfs_state_t;

	typedef struct packed {
		logic        found;
		logic [15:0] image_width;
		logic [15:0] image_height;
	} jfs_result_t;

	localparam jfs_state_t STATE_RESET = '{
		phase: PH_EXPECT_FF, segment_left: 16'd0, marker_code: 8'd0,
		length_high: 8'd0, header_index: '0, held_width: 16'd0,
		held_height: 16'd0, result_given: 1'b0
	};

	function automatic logic is_standalone(input logic [7:0] m);
		return (m == MK_SOI) || (m == MK_EOI) || (m >= MK_RST0 && m <= MK_RST7);
	endfunction

	function automatic logic is_frame_marker(input logic [7:0] m);
		return (m >= MK_SOF0) && (m <= MK_SOF_LAST)
			&& (m != MK_DHT) && (m != MK_JPG) && (m != MK_DAC);
	endfunction

endpackage

@@ sv/jfs_byte_if.sv @@
interface jfs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;

	modport source (output valid, output data_byte, output frame_end, input ready);
	modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

@@ sv/jfs_size_if.sv @@
interface jfs_size_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [15:0] image_width;
	logic [15:0] image_height;

	modport source (output valid, output found, output image_width, output image_height,
		input ready);
	modport sink (input valid, input found, input image_width, input image_height,
		output ready);
endinterface

@@ sv/jpeg_frame_size_scanner.sv @@
// A result is registered in the output stage when the byte that causes it is accepted.
// Throughput: one byte per cycle while the input is not stalled; the parse state advances in a single registered step.
// A two-entry output stage (result register plus skid) lets bytes keep flowing while
// a result waits; input stalls only when both entries are full.
// Reset (arst_n low, asynchronous): scanner waits for the first start byte, output empty.
module jpeg_frame_size_scanner (
	input  logic clk,
	input  logic arst_n,
	jfs_byte_if.sink   stream,
	jfs_size_if.source result
);

	// Parse state, one register set for the whole frame
	jfs_pkg::jfs_state_t  state_q;
	jfs_pkg::jfs_state_t  state_nxt;
	logic                 step_valid;
	jfs_pkg::jfs_result_t step_res;

	// Output stage: result register and a skid entry behind it
	logic                 out_valid_q;
	jfs_pkg::jfs_result_t out_data_q;
	logic                 skid_valid_q;
	jfs_pkg::jfs_result_t skid_data_q;

	logic accept;
	logic push;
	logic take;

	// Stall input only while the skid entry is occupied
	assign stream.ready = !skid_valid_q;
	assign accept = stream.valid && stream.ready;
	assign push = accept && step_valid;
	assign take = out_valid_q && result.ready;

	jfs_step u_step (
		.data_byte (stream.data_byte),
		.frame_end (stream.frame_end),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res_valid (step_valid),
		.res       (step_res)
	);

	// Advance parse state on every accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jfs_pkg::STATE_RESET;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// Fill the output register first; drop into skid when it is held by the sink
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || take) begin
				if (skid_valid_q) begin
					out_valid_q <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= push;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Payload registers: no reset needed
	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			out_data_q <= skid_valid_q ? skid_data_q : step_res;
		end else if (push) begin
			skid_data_q <= step_res;
		end
	end

	assign result.valid = out_valid_q;
	assign result.found = out_data_q.found;
	assign result.image_width = out_data_q.image_width;
	assign result.image_height = out_data_q.image_height;

	// Skid entry is only ever used behind a full result register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds an item while result register is empty");

	// A frame-end byte always rearms the scanner for the next frame
	a_frame_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && stream.frame_end) |=> (state_q.phase == jfs_pkg::PH_EXPECT_FF
			&& !state_q.result_given))
		else $error("scanner not rearmed after frame end");

	// Found means both sizes are nonzero
	a_found_sizes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.found) |-> (out_data_q.image_width != 16'd0
			&& out_data_q.image_height != 16'd0))
		else $error("found reported with a zero size");

	// At most one result per frame: once given, no second push before frame end
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && state_q.result_given) |-> !step_valid)
		else $error("second result in one frame");

endmodule

@@ sv/jfs_step.sv @@
module jfs_step (
	input  logic [7:0]          data_byte,
	input  logic                frame_end,
	input  jfs_pkg::jfs_state_t cur,
	output jfs_pkg::jfs_state_t nxt,
	output logic                res_valid,
	output jfs_pkg::jfs_result_t res
);

	jfs_pkg::jfs_state_t upd;
	logic [15:0]         seg_len;
	logic [15:0]         seg_dec;
	logic                sof_done;

	assign seg_len = {cur.length_high, data_byte};
	assign seg_dec = cur.segment_left - 16'd1;

	always_comb begin
		upd = cur;
		sof_done = 1'b0;
		unique case (cur.phase)
			jfs_pkg::PH_EXPECT_FF: begin
				upd.phase = (data_byte == jfs_pkg::MK_FILL) ? jfs_pkg::PH_EXPECT_D8
					: jfs_pkg::PH_DONE;
			end
			jfs_pkg::PH_EXPECT_D8: begin
				upd.phase = (data_byte == jfs_pkg::MK_SOI) ? jfs_pkg::PH_HUNT
					: jfs_pkg::PH_DONE;
			end
			jfs_pkg::PH_HUNT: begin
				if (data_byte == jfs_pkg::MK_FILL) upd.phase = jfs_pkg::PH_FF_RUN;
			end
			jfs_pkg::PH_FF_RUN: begin
				if (data_byte != jfs_pkg::MK_FILL) begin
					upd.marker_code = data_byte;
					upd.phase = jfs_pkg::is_standalone(data_byte) ? jfs_pkg::PH_HUNT
						: jfs_pkg::PH_LEN_HI;
				end
			end
			jfs_pkg::PH_LEN_HI: begin
				upd.length_high = data_byte;
				upd.phase = jfs_pkg::PH_LEN_LO;
			end
			jfs_pkg::PH_LEN_LO: begin
				if (seg_len < jfs_pkg::LEN_MIN) begin
					upd.phase = jfs_pkg::PH_DONE;
				end else begin
					upd.segment_left = seg_len - jfs_pkg::LEN_MIN;
					if (jfs_pkg::is_frame_marker(cur.marker_code)
						&& seg_len >= jfs_pkg::SOF_LEN_MIN) begin
						upd.header_index = '0;
						upd.held_width = 16'd0;
						upd.held_height = 16'd0;
						upd.phase = jfs_pkg::PH_SOF_BODY;
					end else begin
						upd.phase = (seg_len == jfs_pkg::LEN_MIN) ? jfs_pkg::PH_HUNT
							: jfs_pkg::PH_SKIP;
					end
				end
			end
			jfs_pkg::PH_SKIP: begin
				upd.segment_left = seg_dec;
				if (seg_dec == 16'd0) upd.phase = jfs_pkg::PH_HUNT;
			end
			jfs_pkg::PH_SOF_BODY: begin
				case (cur.header_index)
					jfs_pkg::HDR_H_HI: upd.held_height[15:8] = data_byte;
					jfs_pkg::HDR_H_LO: upd.held_height[7:0] = data_byte;
					jfs_pkg::HDR_W_HI: upd.held_width[15:8] = data_byte;
					jfs_pkg::HDR_W_LO: upd.held_width[7:0] = data_byte;
					default: ;
				endcase
				if (cur.header_index < jfs_pkg::HDR_END)
					upd.header_index = cur.header_index + 1'b1;
				upd.segment_left = seg_dec;
				if (seg_dec == 16'd0) begin
					sof_done = 1'b1;
					upd.result_given = 1'b1;
					upd.phase = jfs_pkg::PH_DONE;
				end
			end
			default: ;
		endcase
	end

	// Result comes from the finished header, or a not-found at frame end.
	always_comb begin
		res_valid = sof_done || (frame_end && !cur.result_given);
		if (sof_done) begin
			res.found = (upd.held_width != 16'd0) && (upd.held_height != 16'd0);
			res.image_width = upd.held_width;
			res.image_height = upd.held_height;
		end else begin
			res = '0;
		end
		nxt = frame_end ? jfs_pkg::STATE_RESET : upd;
	end

endmodule

@@ test/tb_jpeg_frame_size_scanner.sv @@
module tb_jpeg_frame_size_scanner;
	timeunit 1ns;
	timeprecision 1ps;

	import jfs_pkg::*;

	// Marker codes used by the stimulus that the package has no name for
	localparam logic [7:0] MK_APP0  = 8'hE0;
	localparam logic [7:0] MK_STUFF = 8'h00;

	localparam int IDLE_LIMIT = 2000;  // cycles with no item moving on either side
	localparam int HOLD_CYCLES = 300;  // long output hold-off in the pressure test
	localparam int RANDOM_BYTES = 860;
	localparam int RANDOM_FRAMES = 20;

	// Private copy of the scanner state, advanced once per accepted byte
	typedef struct packed {
		logic [PHASE_W-1:0]   phase;
		logic [15:0]          left;
		logic [7:0]           marker;
		logic [7:0]           len_hi;
		logic [HDR_IDX_W-1:0] idx;
		logic [15:0]          width;
		logic [15:0]          height;
		logic                 given;
	} scan_state_t;

	localparam scan_state_t SCAN_IDLE = '{
		phase: PH_EXPECT_FF, left: 16'd0, marker: 8'd0, len_hi: 8'd0,
		idx: '0, width: 16'd0, height: 16'd0, given: 1'b0
	};

	logic clk;
	logic arst_n;

	jfs_byte_if byte_ch ();
	jfs_size_if size_ch ();

	jpeg_frame_size_scanner dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (byte_ch),
		.result (size_ch)
	);

	scan_state_t  scan = SCAN_IDLE;
	jfs_result_t  size_q[$];       // sizes still owed by the block, oldest first
	jfs_result_t  size_exp;
	logic [7:0]   frame_buf[$];    // bytes of the frame about to be sent

	int errors = 0;
	int bytes_sent = 0;
	int frames_sent = 0;
	int found_count = 0;
	int missing_count = 0;
	int stall_cycles = 0;
	int idle_cycles = 0;
	int src_gap_max = 19;
	int snk_stall_max = 19;
	int sink_hold = 0;

	always #1 clk = ~clk;

	// Advance the private scanner by one byte; return 1 when the byte yields a size
	function automatic bit scan_for_size(input logic [7:0] b, input bit last,
		output jfs_result_t r);
		logic [15:0] seg_len;
		bit emit;
		emit = 1'b0;
		r = '0;
		case (scan.phase)
			PH_EXPECT_FF: scan.phase = (b == MK_FILL) ? PH_EXPECT_D8 : PH_DONE;
			PH_EXPECT_D8: scan.phase = (b == MK_SOI) ? PH_HUNT : PH_DONE;
			PH_HUNT: begin
				if (b == MK_FILL)
					scan.phase = PH_FF_RUN;
			end
			PH_FF_RUN: begin
				if (b != MK_FILL) begin
					scan.marker = b;
					// restart and image markers carry no length
					if (b == MK_SOI || b == MK_EOI || (b >= MK_RST0 && b <= MK_RST7))
						scan.phase = PH_HUNT;
					else
						scan.phase = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin
				scan.len_hi = b;
				scan.phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				seg_len = {scan.len_hi, b};
				if (seg_len < LEN_MIN) begin
					scan.phase = PH_DONE;
				end else begin
					scan.left = seg_len - LEN_MIN;
					if (scan.marker >= MK_SOF0 && scan.marker <= MK_SOF_LAST
						&& scan.marker != MK_DHT && scan.marker != MK_JPG
						&& scan.marker != MK_DAC && seg_len >= SOF_LEN_MIN) begin
						scan.idx = '0;
						scan.width = 16'd0;
						scan.height = 16'd0;
						scan.phase = PH_SOF_BODY;
					end else begin
						scan.phase = (scan.left != 16'd0) ? PH_SKIP : PH_HUNT;
					end
				end
			end
			PH_SKIP: begin
				scan.left = scan.left - 16'd1;
				if (scan.left == 16'd0)
					scan.phase = PH_HUNT;
			end
			PH_SOF_BODY: begin
				case (scan.idx)
					HDR_H_HI: scan.height[15:8] = b;
					HDR_H_LO: scan.height[7:0] = b;
					HDR_W_HI: scan.width[15:8] = b;
					HDR_W_LO: scan.width[7:0] = b;
					default: ;
				endcase
				if (scan.idx < HDR_END)
					scan.idx = scan.idx + 1'b1;
				scan.left = scan.left - 16'd1;
				if (scan.left == 16'd0) begin
					r.found = (scan.width != 16'd0) && (scan.height != 16'd0);
					r.image_width = scan.width;
					r.image_height = scan.height;
					emit = 1'b1;
					scan.given = 1'b1;
					scan.phase = PH_DONE;
				end
			end
			default: ;
		endcase
		// The final byte always closes the frame: owe a not-found if nothing came yet
		if (last) begin
			if (!scan.given) begin
				r = '0;
				emit = 1'b1;
			end
			scan = SCAN_IDLE;
		end
		return emit;
	endfunction

	// Offer one byte after a random gap, hold it until taken, then predict
	task automatic send_byte(input logic [7:0] b, input bit last);
		int gap;
		jfs_result_t r;
		gap = $urandom_range(0, src_gap_max);
		// Drop valid only when a gap is wanted, so back-to-back items stay high
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.frame_end <= last;
		do @(posedge clk); while (!byte_ch.ready);
		if (scan_for_size(b, last, r))
			size_q.push_back(r);
		bytes_sent++;
		if (last)
			frames_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_buf[i])
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	function automatic logic [7:0] pick_sof_code();
		logic [7:0] m;
		do m = 8'($urandom_range(MK_SOF0, MK_SOF_LAST));
		while (m == MK_DHT || m == MK_JPG || m == MK_DAC);
		return m;
	endfunction

	// Append one marker segment; payload bytes 1..4 carry the given height and width
	task automatic add_segment(input logic [7:0] m, input logic [15:0] len,
		input logic [15:0] w, input logic [15:0] h);
		int k;
		frame_buf.push_back(MK_FILL);
		repeat ($urandom_range(0, 1)) frame_buf.push_back(MK_FILL);
		frame_buf.push_back(m);
		frame_buf.push_back(len[15:8]);
		frame_buf.push_back(len[7:0]);
		for (k = 0; k < int'(len) - 2; k++) begin
			case (k)
				1: frame_buf.push_back(h[15:8]);
				2: frame_buf.push_back(h[7:0]);
				3: frame_buf.push_back(w[15:8]);
				4: frame_buf.push_back(w[7:0]);
				default: frame_buf.push_back(8'($urandom));
			endcase
		end
	endtask

	// Build a frame: mostly well-formed marker streams, some noise and broken starts
	task automatic build_random_frame();
		int kind, nseg, sel, cut, i;
		logic [7:0] m;
		logic [15:0] w, h;
		bit stop;
		frame_buf.delete();
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom));
		end else if (kind == 1) begin
			frame_buf.push_back(MK_FILL);
			do m = 8'($urandom); while (m == MK_SOI);
			frame_buf.push_back(m);
			repeat ($urandom_range(0, 4)) frame_buf.push_back(8'($urandom));
		end else begin
			frame_buf.push_back(MK_FILL);
			frame_buf.push_back(MK_SOI);
			nseg = $urandom_range(1, 5);
			stop = 0;
			for (i = 0; i < nseg && !stop; i++) begin
				sel = $urandom_range(0, 39);
				if (sel < 6) begin
					// entropy-coded filler between markers
					repeat ($urandom_range(1, 4))
						frame_buf.push_back(8'($urandom_range(0, 254)));
				end else if (sel < 12) begin
					frame_buf.push_back(MK_FILL);
					frame_buf.push_back(8'($urandom_range(MK_RST0, MK_EOI)));
				end else if (sel < 20) begin
					do m = 8'($urandom_range(0, 254)); while (m >= MK_RST0 && m <= MK_EOI);
					add_segment(m, 16'($urandom_range(2, 8)), 16'($urandom), 16'($urandom));
				end else if (sel < 24) begin
					add_segment(pick_sof_code(), 16'($urandom_range(2, 6)),
						16'($urandom), 16'($urandom));
				end else if (sel < 36) begin
					w = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom);
					h = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom);
					add_segment(pick_sof_code(), 16'($urandom_range(7, 10)), w, h);
				end else if (sel < 37) begin
					// long skip: exercise the high length byte
					add_segment(MK_APP0, 16'($urandom_range(256, 300)),
						16'($urandom), 16'($urandom));
				end else if (sel < 38) begin
					frame_buf.push_back(MK_FILL);
					frame_buf.push_back(MK_APP0);
					frame_buf.push_back(8'd0);
					frame_buf.push_back(8'($urandom_range(0, 1)));
				end else begin
					// huge length cut short by the frame end
					frame_buf.push_back(MK_FILL);
					frame_buf.push_back(($urandom_range(0, 1) == 0) ? pick_sof_code() : MK_APP0);
					frame_buf.push_back(8'($urandom_range(128, 255)));
					frame_buf.push_back(8'($urandom));
					repeat ($urandom_range(0, 6)) frame_buf.push_back(8'($urandom));
					stop = 1;
				end
			end
			repeat ($urandom_range(0, 3)) frame_buf.push_back(8'($urandom));
			if ($urandom_range(0, 5) == 0 && frame_buf.size() > 1) begin
				cut = $urandom_range(1, frame_buf.size() - 1);
				frame_buf = frame_buf[0:cut-1];
			end
		end
	endtask

	task automatic test_sof_extremes();
		// Largest sizes, frame end on the last header byte
		frame_buf = '{MK_FILL, MK_SOI, MK_FILL, MK_SOF0, 8'h00, 8'h07,
			8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_frame();
	endtask

	task automatic test_bad_start();
		frame_buf = '{8'h00};
		send_frame();
		frame_buf = '{MK_FILL, 8'h12};
		send_frame();
	endtask

	task automatic test_short_length();
		// FF run, stuffed zero taken as a marker, then a length of one
		frame_buf = '{MK_FILL, MK_SOI, MK_FILL, MK_FILL, MK_STUFF, 8'h00, 8'h01};
		send_frame();
	endtask

	task automatic test_zero_size_and_skips();
		// Start-of-frame too short to hold sizes, then one with a zero height
		frame_buf = '{MK_FILL, MK_SOI, MK_FILL, 8'hC1, 8'h00, 8'h02,
			MK_FILL, 8'hC2, 8'h00, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05};
		send_frame();
	endtask

	task automatic test_truncated();
		frame_buf = '{MK_FILL, MK_SOI, MK_FILL, MK_APP0, 8'h00, 8'h04, 8'hAA};
		send_frame();
	endtask

	task automatic test_output_backpressure();
		// Hold the output off while one-byte frames keep coming: the block must
		// fill its output stage and stall the byte stream
		sink_hold = HOLD_CYCLES;
		src_gap_max = 0;
		repeat (24)
			send_byte(8'($urandom_range(0, 254)), 1'b1);
		src_gap_max = 19;
	endtask

	task automatic test_random_frames();
		int start_bytes, start_frames;
		start_bytes = bytes_sent;
		start_frames = frames_sent;
		while (bytes_sent - start_bytes < RANDOM_BYTES
			|| frames_sent - start_frames < RANDOM_FRAMES) begin
			// Mix stretches of full-rate traffic with random idling on both sides
			src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
			snk_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
			build_random_frame();
			send_frame();
		end
	endtask

	// Receiver: draw a stall per result, honor a long hold-off when asked
	initial begin : size_sink
		int stall;
		size_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sink_hold > 0) begin
				stall = sink_hold;
				sink_hold = 0;
			end else begin
				stall = $urandom_range(0, snk_stall_max);
			end
			if (stall > 0) begin
				size_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			size_ch.ready <= 1'b1;
			do @(posedge clk); while (!size_ch.valid);
		end
	end

	// Compare each size taken from the block with the oldest one owed
	always @(posedge clk) begin
		if (arst_n && size_ch.valid && size_ch.ready) begin
			if (size_q.size() == 0) begin
				$display("%0t: unexpected result found=%0b width=%0d height=%0d", $time,
					size_ch.found, size_ch.image_width, size_ch.image_height);
				errors++;
			end else begin
				size_exp = size_q.pop_front();
				if (size_exp.found)
					found_count++;
				else
					missing_count++;
				if (size_ch.found !== size_exp.found) begin
					$display("%0t: found expected %0b actual %0b", $time,
						size_exp.found, size_ch.found);
					errors++;
				end
				if (size_ch.image_width !== size_exp.image_width) begin
					$display("%0t: image_width expected %0d actual %0d", $time,
						size_exp.image_width, size_ch.image_width);
					errors++;
				end
				if (size_ch.image_height !== size_exp.image_height) begin
					$display("%0t: image_height expected %0d actual %0d", $time,
						size_exp.image_height, size_ch.image_height);
					errors++;
				end
			end
		end
	end

	// Watchdog: count cycles in which no item moves on either channel
	always @(posedge clk) begin
		if (byte_ch.valid && !byte_ch.ready)
			stall_cycles++;
		if ((byte_ch.valid && byte_ch.ready) || (size_ch.valid && size_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no traffic for %0d cycles, %0d results outstanding", $time,
				idle_cycles, size_q.size());
			$display("** jpeg_frame_size_scanner: FAILED **");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n <= 1'b0;
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= 8'd0;
		byte_ch.frame_end <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sof_extremes();
		test_bad_start();
		test_short_length();
		test_zero_size_and_skips();
		test_truncated();
		test_output_backpressure();
		test_random_frames();

		// Drain: wait for every owed size, then watch for strays
		byte_ch.valid <= 1'b0;
		while (size_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Scanned %0d bytes in %0d frames: %0d sizes found, %0d frames without one.",
			bytes_sent, frames_sent, found_count, missing_count);
		$display("Output held off %0d cycles once; byte input stalled %0d cycles in all.",
			HOLD_CYCLES, stall_cycles);
		if (errors == 0)
			$display("** jpeg_frame_size_scanner: PASSED **");
		else
			$display("** jpeg_frame_size_scanner: FAILED **");
		$finish;
	end

endmodule
